// File: hw/rtl/mset_pkg.sv
// Shared types and constants for the multi-slot event timer.
package mset_pkg;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_STOP    = 2'd1,
        OP_RESTART = 2'd2,
        OP_TICK    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FAIL  = 2'd1,
        ST_NOACT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_READ,
        B_EXEC,
        B_END
    } bstate_t;

    localparam logic [15:0] INFINITE_COUNT = 16'hFFFF;
    localparam int          MAX_RESULTS    = 16;
    localparam int          FIRE_W         = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        op_t         op;
        logic [3:0]  slot;
        logic [7:0]  task_id;
        logic [15:0] event_bits;
        logic [15:0] repeat_count;
        logic [31:0] timeout;
        logic [31:0] now;
    } cmd_t;

    typedef struct packed {
        logic [31:0] start_time;
        logic [31:0] interval;
        logic [15:0] count;
        logic [15:0] event_bits;
        logic [7:0]  task_id;
    } rec_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  slot_out;
        logic        fired;
        logic [7:0]  fire_task;
        logic [15:0] fire_event;
    } pend_t;

endpackage

// File: hw/rtl/mset_if.sv
// Valid/ready channel interfaces for requests and responses.
interface mset_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [3:0]  slot;
    logic [7:0]  task_id;
    logic [15:0] event_bits;
    logic [15:0] repeat_count;
    logic [31:0] timeout;
    logic [31:0] now;
    modport source (output valid, mode, slot, task_id, event_bits, repeat_count, timeout, now,
                    input ready);
    modport sink (input valid, mode, slot, task_id, event_bits, repeat_count, timeout, now,
                  output ready);
endinterface

interface mset_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  slot_out;
    logic        fired;
    logic [7:0]  fire_task;
    logic [15:0] fire_event;
    logic [4:0]  active_count;
    logic        last;
    modport source (output valid, status, slot_out, fired, fire_task, fire_event, active_count,
                    last, input ready);
    modport sink (input valid, status, slot_out, fired, fire_task, fire_event, active_count,
                  last, output ready);
endinterface

// File: hw/rtl/multi_slot_event_timer.sv
// Top level of the multi-slot event timer.
//
// Requests arrive on req (valid/ready); each beat is start, stop, restart or
// tick. Responses leave on rsp (valid/ready); every request yields at least
// one response beat, and the final beat of a request carries last.
// Start searches the slot bits one per cycle for the lowest free slot.
// Stop and restart read-modify-write one table entry. A tick walks every
// slot: a free slot is passed over in the read state; an occupied one is
// read, then updated in the exec state, which can wait for the response
// register. Fired slots go out in slot order; one fire is held back so that
// the last beat can be flagged when the walk ends.
// A two-entry command queue in the front end feeds the sequencer, so
// new requests are taken while a command runs or a response waits.
// When the receiver stalls, the response register holds its beat and the
// sequencer waits at its next push; the queue fills, then req.ready drops.
// Reset (rst_n, asynchronous) frees all slots and empties the queue and
// response register; no clearing pass is needed.
module multi_slot_event_timer
#(
    parameter int SLOTS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    mset_req_if.sink   req,
    mset_rsp_if.source rsp
);

    mset_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    // Accept and decode request beats.
    mset_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    // Execute commands against the slot table and drive responses.
    mset_back #(.SLOTS(SLOTS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

endmodule

// File: hw/rtl/mset_front.sv
// Front end: accepts request beats, decodes the mode, queues two commands.
module mset_front
(
    input  logic                clk,
    input  logic                rst_n,
    mset_req_if.sink            req,
    output mset_pkg::cmd_t      cmd,
    output logic                cmd_valid,
    input  logic                cmd_pop
);

    mset_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push;
    logic           pop;
    mset_pkg::cmd_t dec;

    always_comb
    begin
        dec.op           = mset_pkg::op_t'(req.mode);
        dec.slot         = req.slot;
        dec.task_id      = req.task_id;
        dec.event_bits   = req.event_bits;
        dec.repeat_count = req.repeat_count;
        dec.timeout      = req.timeout;
        dec.now          = req.now;
    end

    assign req.ready = (fill_reg != 2'd2);
    assign push      = req.valid && req.ready;
    assign cmd_valid = (fill_reg != 2'd0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

endmodule

// File: hw/rtl/mset_back.sv
// Back end: slot table, command sequencer and response register.
module mset_back
#(
    parameter int SLOTS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  mset_pkg::cmd_t      cmd,
    input  logic                cmd_valid,
    output logic                cmd_pop,
    mset_rsp_if.source          rsp
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

    mset_pkg::rec_t  mem [SLOTS];
    mset_pkg::rec_t  rd_reg;
    mset_pkg::rec_t  wdata;
    logic            we;

    mset_pkg::bstate_t state_reg, state_next;
    mset_pkg::cmd_t  cmd_reg;
    logic [SW-1:0]   idx_reg, idx_next;
    logic [SLOTS-1:0] used_reg, used_next;
    logic [CW-1:0]   active_reg, active_next;
    logic [CW-1:0]   zero_reg, zero_next;
    logic [CW-1:0]   act_reg, act_next;
    mset_pkg::pend_t pend_reg, pend_next;
    logic            pend_v_reg, pend_v_next;
    logic [mset_pkg::FIRE_W-1:0] fires_reg, fires_next;

    logic            out_v_reg, out_v_next;
    mset_pkg::pend_t out_reg, out_next;
    logic [4:0]      out_act_reg, out_act_next;
    logic            out_last_reg, out_last_next;

    logic            can_push;
    logic            slot_ok;
    logic [SW-1:0]   sidx;
    logic            expired;
    logic [15:0]     new_cnt;
    logic [4:0]      cur_act;
    mset_pkg::pend_t fire_res;
    mset_pkg::pend_t empty_res;

    assign can_push = !out_v_reg || rsp.ready;
    assign slot_ok  = ({28'd0, cmd.slot} < 32'(SLOTS));
    assign sidx     = SW'(cmd.slot);
    assign expired  = (cmd_reg.now - rd_reg.start_time) >= rd_reg.interval;
    assign new_cnt  = (rd_reg.count == mset_pkg::INFINITE_COUNT) ? rd_reg.count
                                                                : rd_reg.count - 16'd1;
    assign cur_act  = (cmd_reg.op == mset_pkg::OP_TICK) ? 5'(act_reg) : 5'(active_reg);

    always_comb
    begin
        fire_res.status     = mset_pkg::ST_OK;
        fire_res.slot_out   = 4'(idx_reg);
        fire_res.fired      = 1'b1;
        fire_res.fire_task  = rd_reg.task_id;
        fire_res.fire_event = rd_reg.event_bits;
        empty_res           = '0;
        empty_res.status    = mset_pkg::ST_OK;
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        used_next     = used_reg;
        active_next   = active_reg;
        zero_next     = zero_reg;
        act_next      = act_reg;
        pend_next     = pend_reg;
        pend_v_next   = pend_v_reg;
        fires_next    = fires_reg;
        out_next      = out_reg;
        out_act_next  = out_act_reg;
        out_last_next = out_last_reg;
        out_v_next    = out_v_reg && !rsp.ready;
        cmd_pop       = 1'b0;
        we            = 1'b0;
        wdata         = rd_reg;

        case (state_reg)
            mset_pkg::B_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.op)
                        mset_pkg::OP_START:
                        begin
                            idx_next = '0;
                            if (cmd.repeat_count == 16'd0)
                            begin
                                pend_next        = empty_res;
                                pend_next.status = mset_pkg::ST_FAIL;
                                pend_v_next      = 1'b1;
                                state_next       = mset_pkg::B_END;
                            end
                            else
                            begin
                                state_next = mset_pkg::B_SCAN;
                            end
                        end
                        mset_pkg::OP_STOP, mset_pkg::OP_RESTART:
                        begin
                            pend_next          = empty_res;
                            pend_next.slot_out = cmd.slot;
                            pend_v_next        = 1'b1;
                            if (slot_ok && used_reg[sidx])
                            begin
                                idx_next   = sidx;
                                state_next = mset_pkg::B_READ;
                            end
                            else
                            begin
                                pend_next.status = mset_pkg::ST_NOACT;
                                state_next       = mset_pkg::B_END;
                            end
                        end
                        default:
                        begin
                            idx_next    = '0;
                            pend_v_next = 1'b0;
                            fires_next  = '0;
                            act_next    = active_reg - zero_reg;
                            state_next  = mset_pkg::B_READ;
                        end
                    endcase
                end
            end

            mset_pkg::B_SCAN:
            begin
                if (!used_reg[idx_reg])
                begin
                    we                = 1'b1;
                    wdata.start_time  = cmd_reg.now;
                    wdata.interval    = cmd_reg.timeout;
                    wdata.count       = cmd_reg.repeat_count;
                    wdata.event_bits  = cmd_reg.event_bits;
                    wdata.task_id     = cmd_reg.task_id;
                    used_next[idx_reg] = 1'b1;
                    active_next       = active_reg + CW'(1);
                    pend_next         = empty_res;
                    pend_next.slot_out = 4'(idx_reg);
                    pend_v_next       = 1'b1;
                    state_next        = mset_pkg::B_END;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    pend_next        = empty_res;
                    pend_next.status = mset_pkg::ST_FAIL;
                    pend_v_next      = 1'b1;
                    state_next       = mset_pkg::B_END;
                end
                else
                begin
                    idx_next = idx_reg + SW'(1);
                end
            end

            mset_pkg::B_READ:
            begin
                if (cmd_reg.op == mset_pkg::OP_TICK && !used_reg[idx_reg])
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = mset_pkg::B_END;
                    end
                    else
                    begin
                        idx_next = idx_reg + SW'(1);
                    end
                end
                else
                begin
                    state_next = mset_pkg::B_EXEC;
                end
            end

            mset_pkg::B_EXEC:
            begin
                case (cmd_reg.op)
                    mset_pkg::OP_STOP:
                    begin
                        we          = 1'b1;
                        wdata.count = 16'd0;
                        if (rd_reg.count != 16'd0)
                        begin
                            zero_next = zero_reg + CW'(1);
                        end
                        state_next = mset_pkg::B_END;
                    end
                    mset_pkg::OP_RESTART:
                    begin
                        we               = 1'b1;
                        wdata.start_time = cmd_reg.now;
                        state_next       = mset_pkg::B_END;
                    end
                    default:
                    begin
                        if (rd_reg.count == 16'd0)
                        begin
                            // Stopped or spent slot: free it without firing.
                            used_next[idx_reg] = 1'b0;
                            active_next        = active_reg - CW'(1);
                            zero_next          = zero_reg - CW'(1);
                            state_next = (idx_reg == LAST_IDX) ? mset_pkg::B_END
                                                               : mset_pkg::B_READ;
                            idx_next   = (idx_reg == LAST_IDX) ? idx_reg : idx_reg + SW'(1);
                        end
                        else if (!expired)
                        begin
                            state_next = (idx_reg == LAST_IDX) ? mset_pkg::B_END
                                                               : mset_pkg::B_READ;
                            idx_next   = (idx_reg == LAST_IDX) ? idx_reg : idx_reg + SW'(1);
                        end
                        else if (!(pend_v_reg && !can_push
                                   && fires_reg != mset_pkg::FIRE_W'(mset_pkg::MAX_RESULTS)))
                        begin
                            // Hold one fire back so the final beat can carry last.
                            if (fires_reg != mset_pkg::FIRE_W'(mset_pkg::MAX_RESULTS))
                            begin
                                if (pend_v_reg)
                                begin
                                    out_next      = pend_reg;
                                    out_act_next  = 5'(act_reg);
                                    out_last_next = 1'b0;
                                    out_v_next    = 1'b1;
                                end
                                pend_next   = fire_res;
                                pend_v_next = 1'b1;
                                fires_next  = fires_reg + mset_pkg::FIRE_W'(1);
                            end
                            we          = 1'b1;
                            wdata.count = new_cnt;
                            if (new_cnt != 16'd0)
                            begin
                                wdata.start_time = cmd_reg.now;
                            end
                            else
                            begin
                                zero_next = zero_reg + CW'(1);
                            end
                            state_next = (idx_reg == LAST_IDX) ? mset_pkg::B_END
                                                               : mset_pkg::B_READ;
                            idx_next   = (idx_reg == LAST_IDX) ? idx_reg : idx_reg + SW'(1);
                        end
                    end
                endcase
            end

            mset_pkg::B_END:
            begin
                if (can_push)
                begin
                    out_next      = pend_v_reg ? pend_reg : empty_res;
                    out_act_next  = cur_act;
                    out_last_next = 1'b1;
                    out_v_next    = 1'b1;
                    pend_v_next   = 1'b0;
                    state_next    = mset_pkg::B_IDLE;
                end
            end

            default:
            begin
                state_next = mset_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mset_pkg::B_IDLE;
            used_reg   <= '0;
            active_reg <= '0;
            zero_reg   <= '0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
            fires_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            active_reg <= active_next;
            zero_reg   <= zero_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
            fires_reg  <= fires_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cmd_reg <= cmd;
        end
        idx_reg      <= idx_next;
        act_reg      <= act_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_act_reg  <= out_act_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[idx_reg] <= wdata;
        end
        rd_reg <= mem[idx_reg];
    end

    assign rsp.valid        = out_v_reg;
    assign rsp.status       = out_reg.status;
    assign rsp.slot_out     = out_reg.slot_out;
    assign rsp.fired        = out_reg.fired;
    assign rsp.fire_task    = out_reg.fire_task;
    assign rsp.fire_event   = out_reg.fire_event;
    assign rsp.active_count = out_act_reg;
    assign rsp.last         = out_last_reg;

    a_zero_le_active: assert property (@(posedge clk) disable iff (!rst_n)
        zero_reg <= active_reg)
        else $error("spent-slot count exceeds occupied count");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg == CW'($countones(used_reg)))
        else $error("occupied count out of step with slot bits");

    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mset_pkg::B_IDLE |-> !pend_v_reg)
        else $error("pending response left behind at idle");

    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fires_reg <= mset_pkg::FIRE_W'(mset_pkg::MAX_RESULTS))
        else $error("reported fires exceed the response cap");

endmodule
